@@ design/ffen_pkg.sv @@
// Shared widths, constants and types for the edge-normalized FIR filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ffen_pkg;

	// filter geometry
	localparam int MAX_TAPS    = 32;
	localparam int TAP_W       = $clog2(MAX_TAPS);
	localparam int CNT_W       = TAP_W + 1;
	localparam int D_W         = TAP_W + 1;
	localparam int SEEN_W      = 6;
	localparam int SEEN_MAX    = (1 << SEEN_W) - 1;

	// sample and coefficient formats
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int FRAC_SHIFT  = COEF_BITS - 2;

	// accumulator and rescale widths
	localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W       = PROD_W + TAP_W;
	localparam int TOT_W       = COEF_BITS + TAP_W;
	localparam int SCL_W       = ACC_W + TOT_W;
	localparam int SCL_CNT_W   = $clog2(SCL_W);
	localparam int V_W         = SCL_W + 1 - FRAC_SHIFT;

	// configuration port
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// item operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// sequencer to multiply-accumulate control
	typedef struct packed {
		logic clear;
		logic issue;
		logic hit;
	} mac_ctl_t;

endpackage

@@ design/ffen_mac.sv @@
// Multiply-accumulate unit: one tap product per cycle, registered, then summed.
// Depends on ffen_pkg for widths and the mac_ctl_t control group.
`timescale 1ns / 1ps

module ffen_mac import ffen_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0] tap_sample,
	input  logic signed [COEF_BITS-1:0]   tap_coef,
	output logic signed [ACC_W-1:0]       acc,
	output logic signed [TOT_W-1:0]       partial,
	output logic signed [TOT_W-1:0]       total
);

	logic                        issue_s1;
	logic                        hit_s1;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [TOT_W-1:0]     partial_q;
	logic signed [TOT_W-1:0]     total_q;

	// product stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
			hit_s1   <= ctl.issue && ctl.hit;
		end
	end

	// product stage data
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= PROD_W'(tap_sample) * PROD_W'(tap_coef);
			coef_s1 <= tap_coef;
		end
	end

	// running sums, cleared before each output
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q     <= '0;
			partial_q <= '0;
			total_q   <= '0;
		end else if (issue_s1) begin
			total_q <= total_q + {{(TOT_W-COEF_BITS){coef_s1[COEF_BITS-1]}}, coef_s1};
			if (hit_s1) begin
				acc_q     <= acc_q + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
				partial_q <= partial_q + {{(TOT_W-COEF_BITS){coef_s1[COEF_BITS-1]}}, coef_s1};
			end
		end
	end

	assign acc     = acc_q;
	assign partial = partial_q;
	assign total   = total_q;

endmodule

@@ design/ffen_scale.sv @@
// Edge rescale unit: (acc * total) / partial, truncated toward zero.
// One shared adder does shift-add multiply then restoring divide. Uses ffen_pkg.
`timescale 1ns / 1ps

module ffen_scale import ffen_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] acc,
	input  logic signed [TOT_W-1:0] total,
	input  logic signed [TOT_W-1:0] partial,
	output logic                    done,
	output logic signed [SCL_W-1:0] quot
);

	localparam logic [1:0] SC_IDLE = 2'd0;
	localparam logic [1:0] SC_MUL  = 2'd1;
	localparam logic [1:0] SC_DIV  = 2'd2;

	logic [1:0]           sc_state_q;
	logic [SCL_CNT_W-1:0] step_q;
	logic                 done_q;
	logic [SCL_W-1:0]     work_q;
	logic [SCL_W-1:0]     mcand_q;
	logic [TOT_W-1:0]     mult_q;
	logic [TOT_W-1:0]     div_q;
	logic [TOT_W-1:0]     rem_q;
	logic                 neg_q;

	logic [ACC_W-1:0]     acc_mag;
	logic [TOT_W-1:0]     tot_mag;
	logic [TOT_W-1:0]     part_mag;
	logic [TOT_W:0]       rem_sh;
	logic [SCL_W:0]       op_a;
	logic [SCL_W:0]       op_b;
	logic                 cin;
	logic [SCL_W:0]       sum;

	// operand magnitudes
	assign acc_mag  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
	assign tot_mag  = total[TOT_W-1] ? (~total + TOT_W'(1)) : total;
	assign part_mag = partial[TOT_W-1] ? (~partial + TOT_W'(1)) : partial;

	assign rem_sh = {rem_q, work_q[SCL_W-1]};

	// shared adder: add partial product, or trial subtract of the divisor
	always_comb begin
		op_a = {1'b0, work_q};
		op_b = '0;
		cin  = 1'b0;
		case (sc_state_q)
			SC_MUL: begin
				op_a = {1'b0, work_q};
				op_b = mult_q[0] ? {1'b0, mcand_q} : '0;
				cin  = 1'b0;
			end
			SC_DIV: begin
				op_a = {{(SCL_W-TOT_W){1'b0}}, rem_sh};
				op_b = ~{{(SCL_W+1-TOT_W){1'b0}}, div_q};
				cin  = 1'b1;
			end
			default: begin
				op_a = {1'b0, work_q};
				op_b = '0;
				cin  = 1'b0;
			end
		endcase
	end

	assign sum = op_a + op_b + {{SCL_W{1'b0}}, cin};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_state_q <= SC_IDLE;
			step_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (sc_state_q)
				SC_IDLE: begin
					if (start) begin
						step_q     <= '0;
						sc_state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					if (step_q == SCL_CNT_W'(TOT_W - 1)) begin
						step_q     <= '0;
						sc_state_q <= SC_DIV;
					end else begin
						step_q <= step_q + SCL_CNT_W'(1);
					end
				end
				SC_DIV: begin
					if (step_q == SCL_CNT_W'(SCL_W - 1)) begin
						step_q     <= '0;
						done_q     <= 1'b1;
						sc_state_q <= SC_IDLE;
					end else begin
						step_q <= step_q + SCL_CNT_W'(1);
					end
				end
				default: begin
					sc_state_q <= SC_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (sc_state_q)
			SC_IDLE: begin
				if (start) begin
					work_q  <= '0;
					mcand_q <= {{(SCL_W-ACC_W){1'b0}}, acc_mag};
					mult_q  <= tot_mag;
					div_q   <= part_mag;
					rem_q   <= '0;
					neg_q   <= acc[ACC_W-1] ^ total[TOT_W-1] ^ partial[TOT_W-1];
				end
			end
			SC_MUL: begin
				work_q  <= sum[SCL_W-1:0];
				mcand_q <= {mcand_q[SCL_W-2:0], 1'b0};
				mult_q  <= {1'b0, mult_q[TOT_W-1:1]};
			end
			SC_DIV: begin
				// negative trial difference keeps the shifted remainder
				if (sum[SCL_W]) begin
					rem_q <= rem_sh[TOT_W-1:0];
				end else begin
					rem_q <= sum[TOT_W-1:0];
				end
				work_q <= {work_q[SCL_W-2:0], ~sum[SCL_W]};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quot = neg_q ? (~work_q + SCL_W'(1)) : work_q;

endmodule

@@ design/fir_filter_edge_normalized_unit.sv @@
// Edge-normalized centered FIR filter, top level: sequencer, tap stores, output beat.
// Depends on ffen_pkg, ffen_mac and ffen_scale.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------------
//   item     | item_valid / item_stall    | operation, sample, is_last, tap_index, coefficient
//   result   | result_valid / result_stall| filtered, out_last, saturated, zero_partial
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// a coefficient item, and a sample item with no output, is taken while idle and leaves the block idle
// each output steps the multiply-accumulate loop over T taps (T = taps in use), then drain, evaluate and finish
// a renormalized edge output also passes through the shared multiply/divide unit
// a last sample emits up to T - T/2 outputs back to back through the same loop
// no clearing pass after reset; item_stall is high while an item is in work
// a result beat waits in the output register while result_stall is high
`timescale 1ns / 1ps

module fir_filter_edge_normalized_unit import ffen_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          operation,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          is_last,
	input  logic [TAP_W-1:0]              tap_index,
	input  logic signed [COEF_BITS-1:0]   coefficient,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          out_last,
	output logic                          saturated,
	output logic                          zero_partial
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAC   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_SCALE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [1:0] REG_CLAMP     = 2'd1;
	localparam logic [1:0] REG_NORM      = 2'd2;

	localparam logic [SCL_W:0] RND_HALF =
		{{(SCL_W+1-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};

	// configuration registers
	logic [CNT_W-1:0] tap_count_q;
	logic             clamp_q;
	logic             norm_q;

	// sequencer state
	logic [2:0]        state_q;
	logic [SEEN_W-1:0] seen_q;
	logic [CNT_W-1:0]  t_q;
	logic [TAP_W-1:0]  half_q;
	logic [TAP_W-1:0]  m_q;
	logic [TAP_W-1:0]  k_q;
	logic              flush_q;

	// tap stores
	logic signed [SAMPLE_BITS-1:0] dl_q [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   coef_q [MAX_TAPS];

	// result path
	logic                          zero_out_q;
	logic                          zp_q;
	logic signed [SCL_W-1:0]       sum_q;
	logic                          result_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          out_last_q;
	logic                          sat_q;
	logic                          zp_out_q;

	logic                          cfg_wr;
	logic [1:0]                    reg_idx;
	logic                          acc_item;
	logic                          acc_sample;
	logic                          acc_coef;
	logic [CNT_W-1:0]              t_use;
	logic [TAP_W-1:0]              half_use;
	logic [TAP_W-1:0]              look_use;
	logic [SEEN_W-1:0]             seen_nxt;
	logic                          has_out;
	logic [TAP_W-1:0]              m_first;
	logic [D_W-1:0]                mh;
	logic [D_W-1:0]                d;
	logic                          tap_hit;
	logic                          k_last;
	logic [SEEN_W:0]               edge_lim;
	logic                          edge_hit;
	logic                          fin_load;
	logic                          more_out;
	mac_ctl_t                      mac_ctl;
	logic signed [ACC_W-1:0]       mac_acc;
	logic signed [TOT_W-1:0]       mac_partial;
	logic signed [TOT_W-1:0]       mac_total;
	logic                          scl_start;
	logic                          scl_done;
	logic signed [SCL_W-1:0]       scl_quot;
	logic [SCL_W:0]                rnd;
	logic [V_W-1:0]                v;
	logic                          sat_hi;
	logic                          sat_lo;
	logic signed [SAMPLE_BITS-1:0] sat_val;
	logic signed [SAMPLE_BITS-1:0] fin_val;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_TAP_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, tap_count_q};
			REG_CLAMP:     prdata = {{(DATA_W-1){1'b0}}, clamp_q};
			REG_NORM:      prdata = {{(DATA_W-1){1'b0}}, norm_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_W'(1);
			clamp_q     <= 1'b0;
			norm_q      <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TAP_COUNT: tap_count_q <= pwdata[CNT_W-1:0];
				REG_CLAMP:     clamp_q     <= pwdata[0];
				REG_NORM:      norm_q      <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// item acceptance
	assign item_stall = (state_q != S_IDLE);
	assign acc_item   = item_valid && !item_stall;
	assign acc_sample = acc_item && (operation == OP_SAMPLE);
	assign acc_coef   = acc_item && (operation == OP_COEF);

	// taps in use, window half width and lookahead
	always_comb begin
		if (tap_count_q == '0) begin
			t_use = CNT_W'(1);
		end else if (tap_count_q > CNT_W'(MAX_TAPS)) begin
			t_use = CNT_W'(MAX_TAPS);
		end else begin
			t_use = tap_count_q;
		end
	end

	assign half_use = TAP_W'(t_use >> 1);
	assign look_use = TAP_W'(t_use - CNT_W'(1) - CNT_W'(half_use));
	assign seen_nxt = (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q : seen_q + SEEN_W'(1);
	assign has_out  = SEEN_W'(look_use) < seen_nxt;
	assign m_first  = (is_last && !has_out) ? TAP_W'(seen_nxt - SEEN_W'(1)) : look_use;

	// tap window for the current output
	assign mh      = D_W'(m_q) + D_W'(half_q);
	assign d       = mh - D_W'(k_q);
	assign tap_hit = (D_W'(k_q) <= mh) && (SEEN_W'(d) < seen_q) && (d < D_W'(MAX_TAPS));
	assign k_last  = CNT_W'(k_q) == (t_q - CNT_W'(1));

	// edge test: too few earlier samples, or too few later ones at flush
	assign edge_lim = (SEEN_W+1)'(mh) + (SEEN_W+1)'(1);
	assign edge_hit = ({1'b0, seen_q} < edge_lim) || (flush_q && (m_q < half_q));

	assign fin_load = (state_q == S_FIN) && (!result_valid_q || !result_stall);
	assign more_out = flush_q && (m_q != '0);

	assign mac_ctl.clear = (acc_sample && (is_last || has_out)) || (fin_load && more_out);
	assign mac_ctl.issue = (state_q == S_MAC);
	assign mac_ctl.hit   = tap_hit;

	assign scl_start = (state_q == S_EVAL) && edge_hit && norm_q && (mac_partial != '0);

	ffen_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.tap_sample (dl_q[d[TAP_W-1:0]]),
		.tap_coef   (coef_q[k_q]),
		.acc        (mac_acc),
		.partial    (mac_partial),
		.total      (mac_total)
	);

	ffen_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scl_start),
		.acc     (mac_acc),
		.total   (mac_total),
		.partial (mac_partial),
		.done    (scl_done),
		.quot    (scl_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q  <= '0;
			t_q     <= CNT_W'(1);
			half_q  <= '0;
			m_q     <= '0;
			k_q     <= '0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_sample) begin
						seen_q  <= seen_nxt;
						t_q     <= t_use;
						half_q  <= half_use;
						m_q     <= m_first;
						flush_q <= is_last;
						k_q     <= '0;
						if (is_last || has_out) begin
							state_q <= S_MAC;
						end
					end
				end
				S_MAC: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + TAP_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (scl_start) begin
						state_q <= S_SCALE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCALE: begin
					if (scl_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						if (more_out) begin
							m_q     <= m_q - TAP_W'(1);
							k_q     <= '0;
							state_q <= S_MAC;
						end else begin
							if (flush_q) begin
								seen_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// delay line (newest first) and coefficient store
	always_ff @(posedge clk) begin
		if (acc_sample) begin
			dl_q[0] <= sample;
			for (int i = 1; i < MAX_TAPS; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end
		if (acc_coef) begin
			coef_q[tap_index] <= coefficient;
		end
	end

	// unscaled or rescaled sum ahead of rounding
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			zero_out_q <= edge_hit && !norm_q;
			zp_q       <= edge_hit && norm_q && (mac_partial == '0);
			sum_q      <= {{(SCL_W-ACC_W){mac_acc[ACC_W-1]}}, mac_acc};
		end else if ((state_q == S_SCALE) && scl_done) begin
			sum_q <= scl_quot;
		end
	end

	// round half up to Q1.15, saturate, then clamp negatives
	assign rnd     = {sum_q[SCL_W-1], sum_q} + RND_HALF;
	assign v       = rnd[SCL_W:FRAC_SHIFT];
	assign sat_hi  = !v[V_W-1] && (|v[V_W-2:SAMPLE_BITS-1]);
	assign sat_lo  = v[V_W-1] && !(&v[V_W-2:SAMPLE_BITS-1]);

	always_comb begin
		if (sat_hi) begin
			sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (sat_lo) begin
			sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat_val = v[SAMPLE_BITS-1:0];
		end
		fin_val = (clamp_q && sat_val[SAMPLE_BITS-1]) ? '0 : sat_val;
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			filtered_q <= zero_out_q ? '0 : fin_val;
			sat_q      <= !zero_out_q && (sat_hi || sat_lo);
			zp_out_q   <= zp_q;
			out_last_q <= flush_q && (m_q == '0);
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign out_last     = out_last_q;
	assign saturated    = sat_q;
	assign zero_partial = zp_out_q;

	// output index stays inside the tap window
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> ((CNT_W'(m_q) + CNT_W'(half_q)) < t_q))
		else $error("output index outside tap window");

	// tap counter never passes the taps in use
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (CNT_W'(k_q) < t_q))
		else $error("tap counter out of range");

	// rescale unit answers only while the sequencer waits for it
	a_scale_done: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> (state_q == S_SCALE))
		else $error("rescale done outside scale wait");

	// the final beat of a stream returns the block to idle with the count cleared
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && flush_q && (m_q == '0)) |=> ((state_q == S_IDLE) && (seen_q == '0)))
		else $error("stream end did not clear sample count");

endmodule
